[hw/rtl/skfr_pkg.sv]
// shared types and constants for the serial key frame receiver
// depends on nothing; imported by the top level, skfr_check and skfr_checker
`timescale 1ns / 1ps
`default_nettype none

package skfr_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_PARTIAL   = 3'd0,
    ST_ACCEPT    = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_BAD_TERM  = 3'd4,
    ST_BAD_SUM   = 3'd5
  } status_t;

  // configuration register indexes
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_ID_BYTE    = 2'd1;
  localparam logic [1:0] REG_CLEAR_KEY  = 2'd2;

  // frame terminator
  localparam logic [7:0] TERM_CR = 8'h0d;
  localparam logic [7:0] TERM_LF = 8'h0a;

  // bytes of a complete frame as seen by the checker
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] id;
    logic [7:0] key_hi;
    logic [7:0] key_lo;
    logic [7:0] sum;
    logic [7:0] term_hi;
    logic [7:0] term_lo;
  } frame_fields_t;

endpackage

`default_nettype wire

[hw/rtl/serial_key_frame_receiver_core.sv]
// top level of the serial key frame receiver
// depends on skfr_pkg, skfr_cell, skfr_check
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per transaction and gives one result per byte:
// a status code and the key held after that byte. Bytes shift through a
// row of FRAME_LEN-2 byte cells and the first byte of the frame is held
// aside, so when the last byte of a frame arrives every field sits at a
// fixed place and the id, terminator and checksum are checked in that same
// cycle. A byte is taken every clock cycle while rx_ready is high; its
// result is registered in the output register, and rx_ready stays high
// while that register is empty or being read. No startup sweep is needed:
// the cells never feed a check before the current frame has filled them.
// Configuration writes take effect on the next cycle.
module serial_key_frame_receiver_core #(
  parameter int FRAME_LEN = 7
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [2:0]      status,
  output logic [15:0]     held_key
);

  import skfr_pkg::*;

  localparam int CELLS = FRAME_LEN - 2;
  localparam int CNT_W = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN - 1);

  // configuration
  logic [7:0] start_byte;
  logic [7:0] id_byte;
  logic       clear_key_on_error;

  // frame state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       first_byte;
  logic [15:0]      key_reg;
  logic [15:0]      key_next;
  status_t          status_q;
  status_t          status_next;

  logic          accept;
  logic          last;
  logic [7:0]    first_now;
  logic [7:0]    cell_q [CELLS];
  frame_fields_t fields;
  status_t       verdict;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte         <= 8'd0;
      id_byte            <= 8'd0;
      clear_key_on_error <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte         <= cfg_data;
        REG_ID_BYTE:    id_byte            <= cfg_data;
        REG_CLEAR_KEY:  clear_key_on_error <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign rx_ready = !res_valid || res_ready;
  assign accept   = rx_valid && rx_ready;

  // shift chain of byte cells, newest byte enters cell 0
  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        skfr_cell u_cell (
          .clk      (clk),
          .shift_en (accept),
          .din      (rx_byte),
          .dout     (cell_q[gi])
        );
      end else begin : g_body
        skfr_cell u_cell (
          .clk      (clk),
          .shift_en (accept),
          .din      (cell_q[gi-1]),
          .dout     (cell_q[gi])
        );
      end
    end
  endgenerate

  // frame fields at their cells when the last byte is on rx_byte
  assign first_now      = (count == '0) ? rx_byte : first_byte;
  assign last           = (count == LAST_CNT);
  assign fields.first   = first_now;
  assign fields.id      = cell_q[FRAME_LEN-3];
  assign fields.key_hi  = cell_q[FRAME_LEN-4];
  assign fields.key_lo  = cell_q[FRAME_LEN-5];
  assign fields.sum     = cell_q[FRAME_LEN-6];
  assign fields.term_hi = cell_q[0];
  assign fields.term_lo = rx_byte;

  skfr_check u_check (
    .fields  (fields),
    .id_byte (id_byte),
    .verdict (verdict)
  );

  // per-byte frame decision
  always_comb begin
    status_next = ST_PARTIAL;
    key_next    = key_reg;
    count_next  = count + CNT_W'(1);
    if (first_now != start_byte) begin
      status_next = ST_BAD_START;
      key_next    = 16'd0;
      count_next  = '0;
    end else if (last) begin
      status_next = verdict;
      count_next  = '0;
      if (verdict == ST_ACCEPT) begin
        key_next = {fields.key_hi, fields.key_lo};
      end else if (clear_key_on_error) begin
        key_next = 16'd0;
      end
    end
  end

  // frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      key_reg   <= 16'd0;
      res_valid <= 1'b0;
      status_q  <= ST_PARTIAL;
    end else if (accept) begin
      count     <= count_next;
      key_reg   <= key_next;
      res_valid <= 1'b1;
      status_q  <= status_next;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // first byte of the current frame
  always_ff @(posedge clk) begin
    if (accept && count == '0) begin
      first_byte <= rx_byte;
    end
  end

  assign status   = status_q;
  assign held_key = key_reg;

endmodule

`default_nettype wire

[hw/rtl/skfr_cell.sv]
// one byte cell of the receive shift chain
// depends on nothing; instantiated in a row by the top level
`timescale 1ns / 1ps
`default_nettype none

module skfr_cell (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] din,
  output logic [7:0]      dout
);

  logic [7:0] data;

  // take the byte on din (the neighbor's byte, or the new byte in cell 0) on each accepted transaction
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

`default_nettype wire

[hw/rtl/skfr_check.sv]
// end-of-frame checks: id, then terminator, then 8-bit additive checksum
// depends on skfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module skfr_check (
  input  wire skfr_pkg::frame_fields_t fields,
  input  wire logic [7:0]              id_byte,
  output skfr_pkg::status_t            verdict
);

  import skfr_pkg::*;

  logic [7:0] sum;

  // checksum wraps at 8 bits
  assign sum = fields.first + fields.id + fields.key_hi + fields.key_lo;

  // first failing check wins
  always_comb begin
    if (fields.id != id_byte) begin
      verdict = ST_BAD_ID;
    end else if (fields.term_hi != TERM_CR || fields.term_lo != TERM_LF) begin
      verdict = ST_BAD_TERM;
    end else if (fields.sum != sum) begin
      verdict = ST_BAD_SUM;
    end else begin
      verdict = ST_ACCEPT;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/skfr_checker.sv]
// port-level assertions for the serial key frame receiver
// depends on skfr_pkg; bound to serial_key_frame_receiver_core
`timescale 1ns / 1ps
`default_nettype none

module skfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] held_key
);

  import skfr_pkg::*;

  // a bad start always leaves no key held
  a_bad_start_clears_key: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_BAD_START) |-> (held_key == 16'd0))
    else $error("key held after bad start");

  // no new byte taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !rx_ready)
    else $error("input ready while result stalled");

  // stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(status) && $stable(held_key)))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind serial_key_frame_receiver_core skfr_checker u_skfr_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .status    (status),
  .held_key  (held_key)
);

`default_nettype wire
